FILE: sv/hcmb_pkg.sv
package hcmb_pkg;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_CART  = 3'd2;
  localparam logic [2:0] OP_BOOT  = 3'd3;
  localparam logic [2:0] OP_BTN   = 3'd4;
  localparam logic [2:0] OP_IRQ   = 3'd5;

  localparam logic [15:0] ADDR_P1   = 16'hFF00;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_BDIS = 16'hFF50;

  localparam logic [7:0] DMA_LAST = 8'd159;
  localparam logic [7:0] OAM_PAGE = 8'hFE;

  localparam logic [3:0] RG_BOOT   = 4'd0;
  localparam logic [3:0] RG_DIRECT = 4'd1;
  localparam logic [3:0] RG_ROM    = 4'd2;
  localparam logic [3:0] RG_VRAM   = 4'd3;
  localparam logic [3:0] RG_CRAM   = 4'd4;
  localparam logic [3:0] RG_WRAM   = 4'd5;
  localparam logic [3:0] RG_OAM    = 4'd6;
  localparam logic [3:0] RG_IO     = 4'd7;
  localparam logic [3:0] RG_HRAM   = 4'd8;

  typedef struct packed {
    logic        bus_we;
    logic        cart_we;
    logic        boot_we;
    logic [15:0] addr;
    logic [7:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic        re;
    logic        boot_act;
    logic [7:0]  pad;
    logic [15:0] addr;
  } rd_req_t;

  function automatic logic [7:0] io_reset(input logic [6:0] idx);
    logic [7:0] v;
    case (idx)
      7'h40:   v = 8'h91;
      7'h47:   v = 8'hFC;
      7'h48:   v = 8'hFF;
      7'h49:   v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/hcmb_mem.sv
module hcmb_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcmb_pkg::rd_req_t   rd_i,
  input  hcmb_pkg::wr_req_t   wr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] rom_mem  [32768];
  logic [7:0] boot_mem [256];
  logic [7:0] vram_mem [8192];
  logic [7:0] cram_mem [8192];
  logic [7:0] wram_mem [8192];
  logic [7:0] oam_mem  [160];
  logic [7:0] io_mem   [128];
  logic [7:0] hram_mem [128];
  logic [127:0] io_vld_q;

  logic [7:0] rom_rd_q, boot_rd_q, vram_rd_q, cram_rd_q, wram_rd_q;
  logic [7:0] oam_rd_q, io_rd_q, hram_rd_q, direct_q;
  logic       io_vld_rd_q;
  logic [6:0] io_idx_q;
  logic [3:0] region_q;

  logic [3:0] rd_region;
  logic [7:0] rd_direct;
  logic [3:0] wr_region;
  logic [15:0] ra;
  logic [15:0] wa;

  assign ra = rd_i.addr;
  assign wa = wr_i.addr;

  always_comb begin
    rd_direct = 8'hFF;
    if (rd_i.boot_act && ra[15:8] == 8'h00) begin
      rd_region = hcmb_pkg::RG_BOOT;
    end else if (ra == hcmb_pkg::ADDR_P1) begin
      rd_region = hcmb_pkg::RG_DIRECT;
      rd_direct = rd_i.pad;
    end else if (!ra[15]) begin
      rd_region = hcmb_pkg::RG_ROM;
    end else if (ra < 16'hA000) begin
      rd_region = hcmb_pkg::RG_VRAM;
    end else if (ra < 16'hC000) begin
      rd_region = hcmb_pkg::RG_CRAM;
    end else if (ra < 16'hFE00) begin
      rd_region = hcmb_pkg::RG_WRAM;
    end else if (ra < 16'hFEA0) begin
      rd_region = hcmb_pkg::RG_OAM;
    end else if (ra < 16'hFF00) begin
      rd_region = hcmb_pkg::RG_DIRECT;
    end else if (ra < 16'hFF80) begin
      rd_region = hcmb_pkg::RG_IO;
    end else begin
      rd_region = hcmb_pkg::RG_HRAM;
    end
  end

  // Bus writes never reach ROM or the unused gap; those fall out as the direct code.
  always_comb begin
    if (!wa[15]) begin
      wr_region = hcmb_pkg::RG_DIRECT;
    end else if (wa < 16'hA000) begin
      wr_region = hcmb_pkg::RG_VRAM;
    end else if (wa < 16'hC000) begin
      wr_region = hcmb_pkg::RG_CRAM;
    end else if (wa < 16'hFE00) begin
      wr_region = hcmb_pkg::RG_WRAM;
    end else if (wa < 16'hFEA0) begin
      wr_region = hcmb_pkg::RG_OAM;
    end else if (wa < 16'hFF00) begin
      wr_region = hcmb_pkg::RG_DIRECT;
    end else if (wa < 16'hFF80) begin
      wr_region = hcmb_pkg::RG_IO;
    end else begin
      wr_region = hcmb_pkg::RG_HRAM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rom_rd_q  <= rom_mem[ra[14:0]];
      boot_rd_q <= boot_mem[ra[7:0]];
      vram_rd_q <= vram_mem[ra[12:0]];
      cram_rd_q <= cram_mem[ra[12:0]];
      wram_rd_q <= wram_mem[ra[12:0]];
      if (rd_region == hcmb_pkg::RG_OAM) begin
        oam_rd_q <= oam_mem[ra[7:0]];
      end
      io_rd_q   <= io_mem[ra[6:0]];
      hram_rd_q <= hram_mem[ra[6:0]];
      io_idx_q  <= ra[6:0];
      direct_q  <= rd_direct;
      region_q  <= rd_region;
    end
    if (wr_i.cart_we) begin
      rom_mem[wa[14:0]] <= wr_i.data;
    end
    if (wr_i.boot_we) begin
      boot_mem[wa[7:0]] <= wr_i.data;
    end
    if (wr_i.bus_we) begin
      case (wr_region)
        hcmb_pkg::RG_VRAM: vram_mem[wa[12:0]] <= wr_i.data;
        hcmb_pkg::RG_CRAM: cram_mem[wa[12:0]] <= wr_i.data;
        hcmb_pkg::RG_WRAM: wram_mem[wa[12:0]] <= wr_i.data;
        hcmb_pkg::RG_OAM:  oam_mem[wa[7:0]]   <= wr_i.data;
        hcmb_pkg::RG_IO:   io_mem[wa[6:0]]    <= wr_i.data;
        hcmb_pkg::RG_HRAM: hram_mem[wa[6:0]]  <= wr_i.data;
        default: ;
      endcase
    end
  end

  // IO entries never written read back as their reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_vld_q    <= '0;
      io_vld_rd_q <= 1'b0;
    end else begin
      if (rd_i.re) begin
        io_vld_rd_q <= io_vld_q[ra[6:0]];
      end
      if (wr_i.bus_we && wr_region == hcmb_pkg::RG_IO) begin
        io_vld_q[wa[6:0]] <= 1'b1;
      end
    end
  end

  always_comb begin
    case (region_q)
      hcmb_pkg::RG_BOOT:   rdata_o = boot_rd_q;
      hcmb_pkg::RG_DIRECT: rdata_o = direct_q;
      hcmb_pkg::RG_ROM:    rdata_o = rom_rd_q;
      hcmb_pkg::RG_VRAM:   rdata_o = vram_rd_q;
      hcmb_pkg::RG_CRAM:   rdata_o = cram_rd_q;
      hcmb_pkg::RG_WRAM:   rdata_o = wram_rd_q;
      hcmb_pkg::RG_OAM:    rdata_o = oam_rd_q;
      hcmb_pkg::RG_IO:     rdata_o = io_vld_rd_q ? io_rd_q : hcmb_pkg::io_reset(io_idx_q);
      hcmb_pkg::RG_HRAM:   rdata_o = hram_rd_q;
      default:             rdata_o = 8'hFF;
    endcase
  end

endmodule

FILE: sv/handheld_console_memory_bus.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    op_i, addr_i, data_i, buttons_i, irq_line_i
// out       out_valid_o / out_ready_i  read_data_o
// cfg       cfg_we_i                   cfg_wdata_i (boot_rom_present)
//
// A read goes through the memory read, then the registered result.
// Writes, loads and button updates are done in the accepting cycle; an interrupt
// raise reads IF, then writes it back. A DMA write copies 160 bytes, with
// one read and one OAM write per byte through the single memory instance.
// Reset clears control state and IO valid bits; memories keep their contents.
// A new item is taken only when the sequencer is idle and the output is free.
module handheld_console_memory_bus (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  buttons_i,
  input  logic [2:0]  irq_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_DMA_RD = 3'd2;
  localparam logic [2:0] ST_DMA_WR = 3'd3;
  localparam logic [2:0] ST_IRQ_WR = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] read_data_q, read_data_d;
  logic [1:0] sel_q, sel_d;
  logic [7:0] btn_q, btn_d;
  logic       bdis_q, bdis_d;
  logic       present_q;
  logic [7:0] src_q, src_d;
  logic [7:0] cnt_q, cnt_d;
  logic [2:0] line_q, line_d;
  logic       accept;
  logic [7:0] pad;
  logic [7:0] rdata;
  hcmb_pkg::rd_req_t rd;
  hcmb_pkg::wr_req_t wr;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  always_comb begin
    pad = {2'b11, sel_q, 4'hF};
    if (!sel_q[0]) begin
      pad = pad & {4'hF, btn_q[3:0]};
    end
    if (!sel_q[1]) begin
      pad = pad & {4'hF, btn_q[7:4]};
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    read_data_d = read_data_q;
    sel_d       = sel_q;
    btn_d       = btn_q;
    bdis_d      = bdis_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    line_d      = line_q;
    rd          = '0;
    wr          = '0;
    rd.boot_act = present_q && !bdis_q;
    rd.pad      = pad;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          read_data_d = 8'h00;
          case (op_i)
            hcmb_pkg::OP_READ: begin
              out_valid_d = 1'b0;
              rd.re       = 1'b1;
              rd.addr     = addr_i;
              state_d     = ST_RD;
            end
            hcmb_pkg::OP_WRITE: begin
              if (addr_i == hcmb_pkg::ADDR_BDIS && data_i != 8'h00) begin
                bdis_d = 1'b1;
              end else if (addr_i == hcmb_pkg::ADDR_P1) begin
                sel_d = data_i[5:4];
              end else if (addr_i == hcmb_pkg::ADDR_DMA) begin
                src_d   = data_i;
                cnt_d   = 8'd0;
                state_d = ST_DMA_RD;
              end else begin
                wr.bus_we = 1'b1;
                wr.addr   = addr_i;
                wr.data   = data_i;
              end
            end
            hcmb_pkg::OP_CART: begin
              wr.cart_we = !addr_i[15];
              wr.addr    = addr_i;
              wr.data    = data_i;
            end
            hcmb_pkg::OP_BOOT: begin
              wr.boot_we = (addr_i[15:8] == 8'h00);
              wr.addr    = addr_i;
              wr.data    = data_i;
            end
            hcmb_pkg::OP_BTN: begin
              btn_d = buttons_i;
            end
            hcmb_pkg::OP_IRQ: begin
              rd.re   = 1'b1;
              rd.addr = hcmb_pkg::ADDR_IF;
              line_d  = irq_line_i;
              state_d = ST_IRQ_WR;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        out_valid_d = 1'b1;
        read_data_d = rdata;
        state_d     = ST_IDLE;
      end
      ST_DMA_RD: begin
        // The source page starts on a 256-byte boundary, so no carry out of the count.
        rd.re   = 1'b1;
        rd.addr = {src_q, cnt_q};
        state_d = ST_DMA_WR;
      end
      ST_DMA_WR: begin
        wr.bus_we = 1'b1;
        wr.addr   = {hcmb_pkg::OAM_PAGE, cnt_q};
        wr.data   = rdata;
        if (cnt_q == hcmb_pkg::DMA_LAST) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 8'd1;
          state_d = ST_DMA_RD;
        end
      end
      ST_IRQ_WR: begin
        wr.bus_we = 1'b1;
        wr.addr   = hcmb_pkg::ADDR_IF;
        wr.data   = rdata | (8'd1 << line_q);
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sel_q       <= 2'b11;
      btn_q       <= 8'hFF;
      bdis_q      <= 1'b0;
      present_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      btn_q       <= btn_d;
      bdis_q      <= bdis_d;
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    src_q       <= src_d;
    cnt_q       <= cnt_d;
    line_q      <= line_d;
  end

  hcmb_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdata)
  );

endmodule
